>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants for the text cell writer
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int MAX_ROWS  = 32;
	localparam int MAX_COLS  = 128;
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int RCNT_W    = ROW_W + 1;
	localparam int CCNT_W    = COL_W + 1;
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	localparam logic [RCNT_W-1:0] ROWS_RESET = RCNT_W'(24);
	localparam logic [CCNT_W-1:0] COLS_RESET = CCNT_W'(80);

	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_CARET = 8'h5e;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam int         TAB_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STANDOUT = 2'd2;

	localparam logic [2:0] CMD_PUT   = 3'd0;
	localparam logic [2:0] CMD_MOVE  = 3'd1;
	localparam logic [2:0] CMD_ERASE = 3'd2;
	localparam logic [2:0] CMD_READ  = 3'd3;
	localparam logic [2:0] CMD_DIRTY = 3'd4;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] char_code;
		logic       char_standout;
		logic [4:0] target_row;
		logic [6:0] target_col;
	} cmd_in_t;

	typedef struct packed {
		logic              status;
		logic [4:0]        cursor_row_out;
		logic [6:0]        cursor_col_out;
		logic [8:0]        cell_value;
		logic signed [7:0] span_first;
		logic signed [7:0] span_last;
	} result_t;

	typedef struct packed {
		logic accept;
		logic clr;
		logic rd;
		logic wr;
	} ctl_t;

	typedef struct packed {
		logic go_clear;
		logic go_mem;
		logic clr_last;
		logic more;
	} sts_t;

endpackage

>>> rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencer: clearing sweep, per-cell read/write loop, response strobe
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output tcw_pkg::ctl_t ctl,
	input  tcw_pkg::sts_t sts
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CLEAR = 5'b00010,
		S_READ  = 5'b00100,
		S_WRITE = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t state_q;
	logic   erase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			erase_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (sts.go_clear) begin
							erase_q <= 1'b1;
							state_q <= S_CLEAR;
						end else if (sts.go_mem) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_CLEAR: begin
					if (sts.clr_last) state_q <= erase_q ? S_RESP : S_IDLE;
				end
				S_READ:  state_q <= S_WRITE;
				S_WRITE: state_q <= sts.more ? S_READ : S_RESP;
				S_RESP: begin
					erase_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = (state_q == S_RESP);
	assign ctl.accept = (state_q == S_IDLE) && start;
	assign ctl.clr    = (state_q == S_CLEAR);
	assign ctl.rd     = (state_q == S_READ);
	assign ctl.wr     = (state_q == S_WRITE);

endmodule

>>> rtl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// cell memory, cursor, dirty spans, configuration and result registers
// ----------------------------------------------------------------------------
module tcw_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tcw_pkg::cmd_in_t               cmd,
	input  tcw_pkg::ctl_t                  ctl,
	output tcw_pkg::sts_t                  sts,
	input  logic                           cfg_valid,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcw_pkg::CFG_DAT_W-1:0]  cfg_data,
	output tcw_pkg::result_t               result
);

	typedef enum logic [2:0] {
		M_CHAR = 3'd0,
		M_CTRL = 3'd1,
		M_TAB  = 3'd2,
		M_NL   = 3'd3,
		M_READ = 3'd4
	} mode_t;

	localparam int ROW_W  = tcw_pkg::ROW_W;
	localparam int COL_W  = tcw_pkg::COL_W;
	localparam int RCNT_W = tcw_pkg::RCNT_W;
	localparam int CCNT_W = tcw_pkg::CCNT_W;
	localparam int ADDR_W = tcw_pkg::ADDR_W;

	logic [8:0]        mem [tcw_pkg::MAX_ROWS*tcw_pkg::MAX_COLS];
	logic [8:0]        mem_rd_q;
	logic signed [7:0] df_q [tcw_pkg::MAX_ROWS];
	logic signed [7:0] dl_q [tcw_pkg::MAX_ROWS];

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  x_q;
	logic [RCNT_W-1:0] rows_q;
	logic [CCNT_W-1:0] cols_q;
	logic              stand_q;
	logic [ADDR_W-1:0] clr_q;
	mode_t             mode_q;
	logic              phase_q;
	logic [7:0]        ch_q;
	logic              so_q;
	logic              status_q;
	logic [8:0]        cell_q;
	logic signed [7:0] sf_q;
	logic signed [7:0] sl_q;

	// config write decode with clamp limits
	logic [RCNT_W-1:0] rows_nx;
	logic [CCNT_W-1:0] cols_nx;
	logic              cfg_we;

	assign cfg_we = cfg_valid;

	always_comb begin
		rows_nx = rows_q;
		cols_nx = cols_q;
		if (cfg_we && cfg_index == tcw_pkg::REG_ROWS) begin
			if (cfg_data[5:0] == 6'd0) rows_nx = RCNT_W'(1);
			else if ({2'b00, cfg_data[5:0]} > 8'(tcw_pkg::MAX_ROWS))
				rows_nx = RCNT_W'(tcw_pkg::MAX_ROWS);
			else rows_nx = RCNT_W'(cfg_data[5:0]);
		end
		if (cfg_we && cfg_index == tcw_pkg::REG_COLS) begin
			if (cfg_data == 8'd0) cols_nx = CCNT_W'(1);
			else if ({1'b0, cfg_data} > 9'(tcw_pkg::MAX_COLS))
				cols_nx = CCNT_W'(tcw_pkg::MAX_COLS);
			else cols_nx = CCNT_W'(cfg_data);
		end
	end

	// cell address and value
	logic [COL_W-1:0]  wcol;
	logic [ADDR_W-1:0] addr;
	logic [8:0]        wval;

	assign wcol = (mode_q == M_NL) ? x_q : col_q;
	assign addr = {row_q, wcol};

	always_comb begin
		unique case (mode_q)
			M_CHAR:  wval = {so_q | stand_q, ch_q};
			M_CTRL:  wval = phase_q ? {stand_q, ch_q + tcw_pkg::CH_AT}
			                        : {stand_q, tcw_pkg::CH_CARET};
			M_TAB:   wval = {stand_q, tcw_pkg::CH_SPACE};
			default: wval = {1'b0, tcw_pkg::CH_SPACE};
		endcase
	end

	// cursor advance after one printable cell
	logic [CCNT_W-1:0] nxt_col;
	logic [ROW_W-1:0]  adv_row;
	logic [COL_W-1:0]  adv_col;
	logic              adv_err;
	logic              row_more;

	assign nxt_col  = {1'b0, col_q} + CCNT_W'(1);
	assign row_more = ({1'b0, row_q} + RCNT_W'(1)) < rows_q;

	always_comb begin
		adv_row = row_q;
		adv_col = nxt_col[COL_W-1:0];
		adv_err = 1'b0;
		if (nxt_col >= cols_q) begin
			if (row_more) begin
				adv_row = row_q + ROW_W'(1);
				adv_col = '0;
			end else begin
				adv_col = COL_W'(cols_q - CCNT_W'(1));
				adv_err = 1'b1;
			end
		end
	end

	logic nl_last;
	assign nl_last = ({1'b0, x_q} == (cols_q - CCNT_W'(1)));

	logic more;

	always_comb begin
		unique case (mode_q)
			M_CTRL:  more = !phase_q;
			M_TAB:   more = !adv_err && (adv_col[tcw_pkg::TAB_W-1:0] != '0);
			M_NL:    more = !nl_last;
			default: more = 1'b0;
		endcase
	end

	logic is_put;
	assign is_put       = (cmd.command == tcw_pkg::CMD_PUT);
	assign sts.more     = more;
	assign sts.go_clear = (cmd.command == tcw_pkg::CMD_ERASE);
	assign sts.go_mem   = (is_put && cmd.char_code != tcw_pkg::CH_CR
	                              && cmd.char_code != tcw_pkg::CH_BS)
	                   || (cmd.command == tcw_pkg::CMD_READ);
	assign sts.clr_last = (clr_q == '1);

	logic cell_diff;
	assign cell_diff = ctl.wr && (mode_q != M_READ) && (mem_rd_q != wval);

	// cell memory
	always_ff @(posedge clk) begin
		if (ctl.clr) mem[clr_q] <= {1'b0, tcw_pkg::CH_SPACE};
		else if (cell_diff) mem[addr] <= wval;
		if (ctl.rd) mem_rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (ctl.clr) clr_q <= clr_q + ADDR_W'(1);
	end

	// dirty spans
	logic signed [7:0] wx;
	assign wx = 8'(wcol);

	always_ff @(posedge clk) begin
		if (ctl.clr && clr_q == '0) begin
			for (int i = 0; i < tcw_pkg::MAX_ROWS; i++) begin
				df_q[i] <= '0;
				dl_q[i] <= 8'(cols_q - CCNT_W'(1));
			end
		end else if (ctl.accept && cmd.command == tcw_pkg::CMD_DIRTY
		             && {1'b0, cmd.target_row} < rows_q) begin
			df_q[cmd.target_row[ROW_W-1:0]] <= -8'sd1;
			dl_q[cmd.target_row[ROW_W-1:0]] <= -8'sd1;
		end else if (cell_diff) begin
			if (df_q[row_q] < 0 || wx < df_q[row_q]) df_q[row_q] <= wx;
			if (wx > dl_q[row_q]) dl_q[row_q] <= wx;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= tcw_pkg::ROWS_RESET;
			cols_q  <= tcw_pkg::COLS_RESET;
			stand_q <= 1'b0;
		end else begin
			rows_q <= rows_nx;
			cols_q <= cols_nx;
			if (cfg_we && cfg_index == tcw_pkg::REG_STANDOUT) stand_q <= cfg_data[0];
		end
	end

	// cursor and command registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (ctl.clr && clr_q == '0) begin
			row_q <= '0;
			col_q <= '0;
		end else if (ctl.accept) begin
			if (is_put && cmd.char_code == tcw_pkg::CH_CR) col_q <= '0;
			else if (is_put && cmd.char_code == tcw_pkg::CH_BS) begin
				if (col_q != '0) col_q <= col_q - COL_W'(1);
			end else if (cmd.command == tcw_pkg::CMD_MOVE
			             && {1'b0, cmd.target_row} < rows_q
			             && {1'b0, cmd.target_col} < cols_q) begin
				row_q <= cmd.target_row[ROW_W-1:0];
				col_q <= cmd.target_col[COL_W-1:0];
			end
		end else if (ctl.wr) begin
			if (mode_q == M_NL) begin
				if (nl_last && row_more) begin
					row_q <= row_q + ROW_W'(1);
					col_q <= '0;
				end
			end else if (mode_q != M_READ) begin
				row_q <= adv_row;
				col_q <= adv_col;
			end
		end else if (cfg_we) begin
			if ({1'b0, row_q} >= rows_nx) row_q <= ROW_W'(rows_nx - RCNT_W'(1));
			if ({1'b0, col_q} >= cols_nx) col_q <= COL_W'(cols_nx - CCNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			ch_q     <= cmd.char_code;
			so_q     <= cmd.char_standout;
			phase_q  <= 1'b0;
			x_q      <= col_q;
			status_q <= 1'b0;
			cell_q   <= '0;
			sf_q     <= '0;
			sl_q     <= '0;
			mode_q   <= M_READ;
			unique case (cmd.command)
				tcw_pkg::CMD_PUT: begin
					if (cmd.char_code == tcw_pkg::CH_NL) mode_q <= M_NL;
					else if (cmd.char_code == tcw_pkg::CH_TAB) mode_q <= M_TAB;
					else if (cmd.char_code != 8'd0 && cmd.char_code < tcw_pkg::CH_SPACE)
						mode_q <= M_CTRL;
					else mode_q <= M_CHAR;
				end
				tcw_pkg::CMD_MOVE: begin
					if ({1'b0, cmd.target_row} >= rows_q || {1'b0, cmd.target_col} >= cols_q)
						status_q <= 1'b1;
				end
				tcw_pkg::CMD_ERASE, tcw_pkg::CMD_READ: ;
				tcw_pkg::CMD_DIRTY: begin
					if ({1'b0, cmd.target_row} >= rows_q) begin
						status_q <= 1'b1;
						sf_q     <= -8'sd1;
						sl_q     <= -8'sd1;
					end else begin
						sf_q <= df_q[cmd.target_row[ROW_W-1:0]];
						sl_q <= dl_q[cmd.target_row[ROW_W-1:0]];
					end
				end
				default: status_q <= 1'b1;
			endcase
		end else if (ctl.wr) begin
			unique case (mode_q)
				M_CHAR: status_q <= adv_err;
				M_CTRL: begin
					phase_q <= 1'b1;
					if (phase_q) status_q <= adv_err;
				end
				M_TAB:  if (adv_err) status_q <= 1'b1;
				M_NL:   x_q <= x_q + COL_W'(1);
				M_READ: cell_q <= mem_rd_q;
				default: ;
			endcase
		end
	end

	assign result.status         = status_q;
	assign result.cursor_row_out = 5'(row_q);
	assign result.cursor_col_out = 7'(col_q);
	assign result.cell_value     = cell_q;
	assign result.span_first     = sf_q;
	assign result.span_last      = sl_q;

endmodule

>>> rtl/text_cell_writer_with_dirty_spans_core.sv
// ----------------------------------------------------------------------------
// text_cell_writer_with_dirty_spans_core
// character-cell window with cursor, control-code handling and dirty spans
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// command   in         start & !busy           cmd    (cmd_in_t)
// result    out        done, one-cycle strobe  result (result_t)
// config    in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// cursor moves, return, backspace, dirty read and bad commands go from idle straight to the result
// put char and read cell read then compare/write each cell touched (on the single memory
// port); newline touches every cell to the end of the row
// erase sweeps all 4096 cells, one cell a cycle, before the result strobe
// the clearing sweep after reset keeps busy high until every cell is cleared
// busy stays high through the result strobe cycle; results cannot be held off
// configuration is taken every cycle, also during the sweep
module text_cell_writer_with_dirty_spans_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tcw_pkg::cmd_in_t              cmd,
	output logic                          done,
	output tcw_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcw_pkg::CFG_DAT_W-1:0] cfg_data
);

	tcw_pkg::ctl_t ctl;
	tcw_pkg::sts_t sts;

	// register writes never stall
	assign cfg_ready = 1'b1;

	// sequencer
	tcw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl),
		.sts    (sts)
	);

	// cells, cursor, spans and the result registers
	tcw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule
